[sv/sle_pkg.sv]
// ----------------------------------------------------------------------------
// sle_pkg: shared types and codes for the sequential list engine
// Command codes and the packed request and response transaction types.
// ----------------------------------------------------------------------------
package sle_pkg;

	localparam int POS_W = 7;
	localparam int OPV_W = 32;

	// command codes
	localparam logic [2:0] CMD_INSERT  = 3'd0;
	localparam logic [2:0] CMD_DELETE  = 3'd1;
	localparam logic [2:0] CMD_LOCATE  = 3'd2;
	localparam logic [2:0] CMD_DELMIN  = 3'd3;
	localparam logic [2:0] CMD_REVERSE = 3'd4;
	localparam logic [2:0] CMD_REMALL  = 3'd5;
	localparam logic [2:0] CMD_READ    = 3'd6;

	typedef struct packed {
		logic [2:0]              cmd;
		logic [POS_W-1:0]        position;
		logic signed [OPV_W-1:0] operand_value;
	} sle_req_t;

	typedef struct packed {
		logic                    ok;
		logic signed [OPV_W-1:0] result_value;
		logic [POS_W-1:0]        found_position;
		logic [POS_W-1:0]        list_count;
	} sle_rsp_t;

endpackage

[sv/sequential_list_engine.sv]
// ----------------------------------------------------------------------------
// sequential_list_engine: contiguous list of signed words in one memory
// Insert, delete, locate, delete-min, reverse, remove-all and read commands.
// ----------------------------------------------------------------------------
// Usage
//   A command transaction is taken on the rising edge where start is high and
//   busy is low; busy stays high until the command has finished. Exactly one
//   response follows each command: done pulses for one cycle with rsp valid,
//   and the receiver must take it then (it cannot stall the block).
//   All entries live in one synchronous memory with one read and one write
//   port and a registered read. Insert, delete, locate, delete-min,
//   remove-all and reverse walk it one entry a cycle; the single memory
//   read port sets that pace. A rejected command, or a reverse of fewer
//   than two entries, responds without busy going high. Delete-min scans
//   for the minimum and then removes it with the delete walk, which makes
//   it the slowest command. Reset empties the list at once; the memory is
//   not cleared, since only entries below the count are ever used.
// ----------------------------------------------------------------------------
module sequential_list_engine #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  sle_pkg::sle_req_t req,
	output logic              done,
	output sle_pkg::sle_rsp_t rsp
);
	import sle_pkg::*;

	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam int XW = ((CW > POS_W) ? CW : POS_W) + 1;

	// FSM codes
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_INS     = 4'd1;
	localparam logic [3:0] ST_RM      = 4'd2;
	localparam logic [3:0] ST_SCAN    = 4'd3;
	localparam logic [3:0] ST_REV_A   = 4'd4;
	localparam logic [3:0] ST_REV_B   = 4'd5;
	localparam logic [3:0] ST_REV_END = 4'd6;
	localparam logic [3:0] ST_RD      = 4'd7;
	localparam logic [3:0] ST_RD_OUT  = 4'd8;

	// entry storage and its read register
	logic [WIDTH-1:0] entries_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	logic             mem_we;
	logic [AW-1:0]    mem_wa;
	logic [WIDTH-1:0] mem_wd;
	logic [AW-1:0]    mem_ra;

	// control and working registers
	logic [3:0]       state_q;
	logic [2:0]       op_q;
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    j_q;
	logic [CW-1:0]    found_q;
	logic [AW-1:0]    idx_q;
	logic [AW-1:0]    k_q;
	logic [AW-1:0]    wi_q;
	logic [AW-1:0]    wk_q;
	logic             prev_q;
	logic [WIDTH-1:0] val_q;
	logic [WIDTH-1:0] min_q;
	logic [WIDTH-1:0] hold_q;
	logic [WIDTH-1:0] res_q;
	logic             vld_s1;
	logic [AW-1:0]    idx_s1;
	logic             done_q;
	sle_rsp_t         rsp_q;

	// request decode
	logic [OPV_W+63:0] opv_ext;
	logic [WIDTH-1:0]  val_in;
	logic [XW-1:0]     pos_x;
	logic [XW-1:0]     cnt_x;
	logic [XW-1:0]     pos_m1;
	logic              ins_ok;
	logic              pos_ok;
	logic [CW-1:0]     i_dec;

	function automatic logic [OPV_W-1:0] to_res(input logic [WIDTH-1:0] v);
		logic [WIDTH+OPV_W-1:0] t;
		t = {{OPV_W{1'b0}}, v};
		return t[OPV_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] to_pos(input logic [CW-1:0] c);
		logic [CW+POS_W-1:0] t;
		t = {{POS_W{1'b0}}, c};
		return t[POS_W-1:0];
	endfunction

	assign opv_ext = {{64{req.operand_value[OPV_W-1]}}, req.operand_value};
	assign val_in  = opv_ext[WIDTH-1:0];
	assign pos_x   = XW'(req.position);
	assign cnt_x   = XW'(cnt_q);
	assign pos_m1  = pos_x - XW'(1);
	assign ins_ok  = (pos_x != '0) && (pos_x <= cnt_x + XW'(1)) && (cnt_q < CW'(DEPTH));
	assign pos_ok  = (pos_x != '0) && (pos_x <= cnt_x);
	assign i_dec   = i_q - CW'(1);

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;
	assign rsp  = rsp_q;

	// memory port steering
	always_comb begin
		mem_we = 1'b0;
		mem_wa = idx_s1;
		mem_wd = rd_data_q;
		mem_ra = i_q[AW-1:0];
		unique case (state_q)
			ST_INS: begin
				mem_ra = i_dec[AW-1:0];
				if (vld_s1) begin
					mem_we = 1'b1;
					mem_wa = idx_s1 + AW'(1);
				end else if (i_q == CW'(idx_q)) begin
					mem_we = 1'b1;
					mem_wa = idx_q;
					mem_wd = val_q;
				end
			end
			ST_RM: begin
				if (vld_s1 && (idx_s1 != idx_q)) begin
					mem_we = 1'b1;
					mem_wa = idx_s1 - AW'(1);
				end
			end
			ST_SCAN: begin
				if (vld_s1 && (op_q == CMD_REMALL) && (rd_data_q != val_q)) begin
					mem_we = 1'b1;
					mem_wa = j_q[AW-1:0];
				end
			end
			ST_REV_A: begin
				mem_ra = i_q[AW-1:0];
				if (prev_q) begin
					mem_we = 1'b1;
					mem_wa = wi_q;
				end
			end
			ST_REV_B: begin
				mem_ra = k_q;
				if (prev_q) begin
					mem_we = 1'b1;
					mem_wa = wk_q;
					mem_wd = hold_q;
				end
			end
			ST_REV_END: begin
				mem_we = 1'b1;
				mem_wa = wk_q;
				mem_wd = hold_q;
			end
			ST_RD: begin
				mem_ra = idx_q;
			end
			default: begin
			end
		endcase
	end

	// single-port-per-direction memory, registered read
	always_ff @(posedge clk) begin
		if (mem_we) begin
			entries_q[mem_wa] <= mem_wd;
		end
		rd_data_q <= entries_q[mem_ra];
	end

	// command sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			op_q    <= CMD_INSERT;
			cnt_q   <= '0;
			i_q     <= '0;
			j_q     <= '0;
			found_q <= '0;
			idx_q   <= '0;
			k_q     <= '0;
			wi_q    <= '0;
			wk_q    <= '0;
			prev_q  <= 1'b0;
			val_q   <= '0;
			min_q   <= '0;
			hold_q  <= '0;
			res_q   <= '0;
			vld_s1  <= 1'b0;
			idx_s1  <= '0;
			done_q  <= 1'b0;
			rsp_q   <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						val_q   <= val_in;
						op_q    <= req.cmd;
						vld_s1  <= 1'b0;
						res_q   <= '0;
						found_q <= '0;
						i_q     <= '0;
						j_q     <= '0;
						prev_q  <= 1'b0;
						case (req.cmd) inside
							CMD_INSERT: begin
								if (ins_ok) begin
									idx_q   <= pos_m1[AW-1:0];
									i_q     <= cnt_q;
									state_q <= ST_INS;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '{1'b0, '0, '0, to_pos(cnt_q)};
								end
							end
							CMD_DELETE: begin
								if (pos_ok) begin
									idx_q   <= pos_m1[AW-1:0];
									i_q     <= pos_m1[CW-1:0];
									state_q <= ST_RM;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '{1'b0, '0, '0, to_pos(cnt_q)};
								end
							end
							CMD_LOCATE, CMD_REMALL: begin
								state_q <= ST_SCAN;
							end
							CMD_DELMIN: begin
								if (cnt_q != '0) begin
									state_q <= ST_SCAN;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '{1'b0, '0, '0, to_pos(cnt_q)};
								end
							end
							CMD_REVERSE: begin
								if (cnt_q >= CW'(2)) begin
									k_q     <= AW'(cnt_q - CW'(1));
									state_q <= ST_REV_A;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '{1'b1, '0, '0, to_pos(cnt_q)};
								end
							end
							CMD_READ: begin
								if (pos_ok) begin
									idx_q   <= pos_m1[AW-1:0];
									state_q <= ST_RD;
								end else begin
									done_q <= 1'b1;
									rsp_q  <= '{1'b0, '0, '0, to_pos(cnt_q)};
								end
							end
							default: begin
								done_q <= 1'b1;
								rsp_q  <= '{1'b0, '0, '0, to_pos(cnt_q)};
							end
						endcase
					end
				end

				// shift up from the top, then drop the new value in
				ST_INS: begin
					if (i_q > CW'(idx_q)) begin
						vld_s1 <= 1'b1;
						idx_s1 <= i_dec[AW-1:0];
						i_q    <= i_dec;
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							cnt_q   <= cnt_q + CW'(1);
							done_q  <= 1'b1;
							rsp_q   <= '{1'b1, '0, '0, to_pos(cnt_q + CW'(1))};
							state_q <= ST_IDLE;
						end
					end
				end

				// capture the removed entry, then shift the tail down
				ST_RM: begin
					if (vld_s1 && (idx_s1 == idx_q)) begin
						res_q <= rd_data_q;
					end
					if (i_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= i_q[AW-1:0];
						i_q    <= i_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							cnt_q   <= cnt_q - CW'(1);
							done_q  <= 1'b1;
							rsp_q   <= '{1'b1, to_res(res_q), '0, to_pos(cnt_q - CW'(1))};
							state_q <= ST_IDLE;
						end
					end
				end

				// linear walk for locate, delete-min and remove-all
				ST_SCAN: begin
					if (vld_s1) begin
						case (op_q)
							CMD_LOCATE: begin
								if ((found_q == '0) && (rd_data_q == val_q)) begin
									found_q <= CW'(idx_s1) + CW'(1);
								end
							end
							CMD_DELMIN: begin
								if ((idx_s1 == '0) || ($signed(rd_data_q) < $signed(min_q))) begin
									min_q <= rd_data_q;
									idx_q <= idx_s1;
								end
							end
							default: begin
								if (rd_data_q != val_q) begin
									j_q <= j_q + CW'(1);
								end
							end
						endcase
					end
					if (i_q < cnt_q) begin
						vld_s1 <= 1'b1;
						idx_s1 <= i_q[AW-1:0];
						i_q    <= i_q + CW'(1);
					end else begin
						vld_s1 <= 1'b0;
						if (!vld_s1) begin
							case (op_q)
								CMD_LOCATE: begin
									done_q  <= 1'b1;
									rsp_q   <= '{1'b1, '0, to_pos(found_q), to_pos(cnt_q)};
									state_q <= ST_IDLE;
								end
								CMD_DELMIN: begin
									i_q     <= CW'(idx_q);
									state_q <= ST_RM;
								end
								default: begin
									cnt_q   <= j_q;
									done_q  <= 1'b1;
									rsp_q   <= '{1'b1, '0, '0, to_pos(j_q)};
									state_q <= ST_IDLE;
								end
							endcase
						end
					end
				end

				// reverse: read low, read high, write both back interleaved
				ST_REV_A: begin
					if (CW'(i_q) < CW'(k_q)) begin
						state_q <= ST_REV_B;
					end else begin
						state_q <= ST_REV_END;
					end
				end
				ST_REV_B: begin
					hold_q  <= rd_data_q;
					wi_q    <= i_q[AW-1:0];
					wk_q    <= k_q;
					prev_q  <= 1'b1;
					i_q     <= i_q + CW'(1);
					k_q     <= k_q - AW'(1);
					state_q <= ST_REV_A;
				end
				ST_REV_END: begin
					done_q  <= 1'b1;
					rsp_q   <= '{1'b1, '0, '0, to_pos(cnt_q)};
					state_q <= ST_IDLE;
				end

				// single read
				ST_RD: begin
					state_q <= ST_RD_OUT;
				end
				ST_RD_OUT: begin
					done_q  <= 1'b1;
					rsp_q   <= '{1'b1, to_res(rd_data_q), '0, to_pos(cnt_q)};
					state_q <= ST_IDLE;
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
